// File: rtl/msgp_pkg.sv
// Shared types, constants and helpers for the MIDI running-status parser.
// No dependencies; used by msgp_decode and midi_running_status_parser.
package msgp_pkg;

  localparam logic [3:0] TypeNoteOff  = 4'h8;
  localparam logic [3:0] TypeNoteOn   = 4'h9;
  localparam logic [3:0] TypePolyAt   = 4'hA;
  localparam logic [3:0] TypeCtrl     = 4'hB;
  localparam logic [3:0] TypeProgram  = 4'hC;
  localparam logic [3:0] TypeChanAt   = 4'hD;
  localparam logic [3:0] TypePitch    = 4'hE;
  localparam logic [3:0] TypeSystem   = 4'hF;

  localparam logic [1:0] LenOne   = 2'd1;
  localparam logic [1:0] LenTwo   = 2'd2;
  localparam logic [1:0] LenThree = 2'd3;

  typedef struct packed {
    logic [7:0] running_status;
    logic [7:0] current_status;
    logic [1:0] bytes_needed;
    logic [7:0] first_data;
    logic       have_first;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic [1:0] msg_length;
  } midi_msg_t;

  // Data bytes that follow a status: 2, 1, or 0 for none.
  function automatic logic [1:0] data_count(input logic [7:0] status);
    logic [1:0] n;
    n = 2'd0;
    case (status[7:4])
      TypeNoteOff, TypeNoteOn, TypePolyAt, TypeCtrl, TypePitch: n = 2'd2;
      TypeProgram, TypeChanAt: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/msgp_decode.sv
// Per-byte next-state and message decode for the MIDI parser.
// Pure combinational; depends on msgp_pkg.
module msgp_decode (
  input  logic [7:0]            byte_i,
  input  msgp_pkg::parse_state_t state_i,
  output msgp_pkg::parse_state_t state_o,
  output logic                  emit_o,
  output msgp_pkg::midi_msg_t   msg_o
);
  import msgp_pkg::*;

  logic [1:0] run_cnt;
  logic [7:0] st3;

  assign run_cnt = data_count(state_i.running_status);

  // note-on with zero velocity goes out as note-off
  always_comb begin
    st3 = state_i.current_status;
    if (state_i.current_status[7:4] == TypeNoteOn && byte_i == 8'h00) begin
      st3 = {TypeNoteOff, state_i.current_status[3:0]};
    end
  end

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    msg_o   = '0;
    if (state_i.bytes_needed != 2'd0) begin
      // inside a message every byte is data, status bits or not
      if (state_i.bytes_needed[1]) begin
        state_o.first_data   = byte_i;
        state_o.have_first   = 1'b1;
        state_o.bytes_needed = 2'd1;
      end else begin
        state_o.bytes_needed = 2'd0;
        emit_o               = 1'b1;
        if (state_i.have_first) begin
          state_o.have_first = 1'b0;
          msg_o = '{status_byte: st3, data_one: state_i.first_data,
                    data_two: byte_i, msg_length: LenThree};
        end else begin
          msg_o = '{status_byte: state_i.current_status, data_one: byte_i,
                    data_two: 8'h00, msg_length: LenTwo};
        end
      end
    end else if (byte_i[7:4] == TypeSystem) begin
      // system and realtime bytes dropped while idle
    end else if (byte_i[7]) begin
      state_o.running_status = byte_i;
      state_o.current_status = byte_i;
      state_o.bytes_needed   = data_count(byte_i);
      state_o.have_first     = 1'b0;
    end else begin
      state_o.current_status = state_i.running_status;
      case (run_cnt)
        2'd2: begin
          state_o.first_data   = byte_i;
          state_o.have_first   = 1'b1;
          state_o.bytes_needed = 2'd1;
        end
        2'd1: begin
          emit_o = 1'b1;
          msg_o  = '{status_byte: state_i.running_status, data_one: byte_i,
                     data_two: 8'h00, msg_length: LenTwo};
        end
        default: begin
          emit_o = 1'b1;
          msg_o  = '{status_byte: state_i.running_status, data_one: 8'h00,
                     data_two: 8'h00, msg_length: LenOne};
        end
      endcase
    end
  end

endmodule

// File: rtl/midi_running_status_parser.sv
// Top level of the MIDI running-status channel-message parser.
// Input register, msgp_decode, parse state and result register; uses msgp_pkg.
//
//   channel | valid / ready          | payload
//   --------+------------------------+--------------------------------------------
//   in      | in_valid_i / in_ready_o | in_byte_i
//   out     | out_valid_o/out_ready_i | status_byte_o data_one_o data_two_o msg_length_o
//
// One byte per cycle sustained while results are taken; a byte enters the input
// register, is decoded against the parse state, and a completed message lands
// in the result register, which raises out_valid_o.
// Reset clears the parse state and both valid flags.
// A held result stalls decode; in_ready_o drops once the input register also
// holds a beat, and follows out_ready_i combinationally while it does.
module midi_running_status_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] status_byte_o,
  output logic [7:0] data_one_o,
  output logic [7:0] data_two_o,
  output logic [1:0] msg_length_o
);
  import msgp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  parse_state_t state_q, state_d;
  logic         out_valid_q;
  midi_msg_t    msg_q, msg_d;
  logic         emit;
  logic         advance;

  msgp_decode u_decode (
    .byte_i  (in_byte_q),
    .state_i (state_q),
    .state_o (state_d),
    .emit_o  (emit),
    .msg_o   (msg_d)
  );

  // decode the held beat when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
    if (advance && emit) begin
      msg_q <= msg_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_byte_o = msg_q.status_byte;
  assign data_one_o    = msg_q.data_one;
  assign data_two_o    = msg_q.data_two;
  assign msg_length_o  = msg_q.msg_length;

`ifndef SYNTHESIS
  a_need_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_needed != 2'd3)
    else $error("bytes_needed reached three");

  a_first_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.have_first |-> state_q.bytes_needed == 2'd1)
    else $error("first data held without one byte pending");

  a_no_zero_vel_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_length_o == LenThree |->
      !(status_byte_o[7:4] == TypeNoteOn && data_two_o == 8'h00))
    else $error("note-on with zero velocity emitted");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(msg_q))
    else $error("pending message overwritten");
`endif

endmodule
